// ===== src/lppd_pkg.sv =====
// Package for the length-prefixed packet deframer.
// Holds the channel payload structs, the front-to-back command format and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

    // Fixed header layout
    localparam int SIZE_LO_POS = 2;
    localparam int SIZE_HI_POS = 3;
    localparam int ID_POS      = 6;
    localparam int ID_BYTES    = 4;
    localparam int CONN_ID_W   = 32;

    // Command queue between front and back; holds the body beats that arrive
    // while a header bursts out
    localparam int CMD_DEPTH   = 32;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_last;
        logic       size_error;
    } t_out;

    typedef enum logic [1:0] {
        CMD_BODY,
        CMD_HDR,
        CMD_ERR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       last;
        logic       bank;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_hdr_done;

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } t_back_state;

endpackage

`default_nettype wire

// ===== src/lppd_cmd_fifo.sv =====
// Command queue between the deframer front and back.
// Register based, CMD_DEPTH entries; depends on lppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lppd_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output lppd_pkg::t_cmd     o_cmd,
    output logic               o_empty,
    output logic [$clog2(lppd_pkg::CMD_DEPTH):0] o_count
);

    localparam int PTR_W = $clog2(lppd_pkg::CMD_DEPTH);

    lppd_pkg::t_cmd r_mem [lppd_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (PTR_W+1)'(1);
            2'b01:   n_count = r_count - (PTR_W+1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PTR_W+1)'(lppd_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== src/lppd_front.sv =====
// Deframer front: takes stream bytes, gathers headers into two banks, checks the size
// and pushes body, header-burst and error commands. Depends on lppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppd_front #(
    parameter int HEADER_BYTES = 10,
    parameter int MAX_PACKET   = 6144
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire lppd_pkg::t_in      i_in_data,
    output logic                    o_push,
    output lppd_pkg::t_cmd          o_cmd,
    input  wire logic               i_full,
    input  wire lppd_pkg::t_hdr_done i_hdr_done,
    output logic [1:0][HEADER_BYTES-1:0][7:0] o_hdr_bank
);

    localparam int LEN_W  = $clog2(MAX_PACKET + 1);
    localparam int HIDX_W = $clog2(HEADER_BYTES);
    localparam logic [15:0] HB_16  = 16'(HEADER_BYTES);
    localparam logic [15:0] MAX_16 = 16'(MAX_PACKET);
    localparam bit HI_IS_LAST = (HEADER_BYTES - 1 == lppd_pkg::SIZE_HI_POS);

    logic [1:0][HEADER_BYTES-1:0][7:0] r_hdr;
    logic [LEN_W-1:0] r_seen, n_seen;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_discard, n_discard;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_busy, n_busy;

    logic              w_accept;
    logic              w_hdr_phase;
    logic [HIDX_W-1:0] w_hidx;
    logic              w_hdr_complete;
    logic [LEN_W-1:0]  w_seen_inc;
    logic [7:0]        w_size_hi;
    logic [15:0]       w_size;
    logic              w_size_bad;
    logic              w_size_min;

    assign w_hdr_phase = (r_seen < LEN_W'(HEADER_BYTES));
    assign w_hidx      = r_seen[HIDX_W-1:0];
    assign w_seen_inc  = r_seen + LEN_W'(1);

    // stall when the queue is full, and hold header bytes while the back still bursts out this bank
    assign o_in_stall = i_full || (!r_discard && w_hdr_phase && r_busy[r_wbank]);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_hdr_complete = (w_hidx == HIDX_W'(HEADER_BYTES - 1));
    // with a four byte header the completing byte is the size high byte itself
    assign w_size_hi  = HI_IS_LAST ? i_in_data.rx_byte
                                   : r_hdr[r_wbank][lppd_pkg::SIZE_HI_POS];
    assign w_size     = {w_size_hi, r_hdr[r_wbank][lppd_pkg::SIZE_LO_POS]};
    assign w_size_bad = (w_size < HB_16) || (w_size > MAX_16);
    assign w_size_min = (w_size == HB_16);

    always_comb begin
        n_seen      = r_seen;
        n_len       = r_len;
        n_discard   = r_discard;
        n_wbank     = r_wbank;
        n_busy      = r_busy;
        o_push      = 1'b0;
        o_cmd.kind  = lppd_pkg::CMD_BODY;
        o_cmd.data  = i_in_data.rx_byte;
        o_cmd.last  = 1'b0;
        o_cmd.bank  = r_wbank;

        if (i_hdr_done.valid) begin
            n_busy[i_hdr_done.bank] = 1'b0;
        end

        if (w_accept) begin
            if (r_discard) begin
                if (i_in_data.chunk_end) begin
                    n_discard = 1'b0;
                end
            end else if (w_hdr_phase) begin
                n_seen = w_seen_inc;
                if (w_hdr_complete) begin
                    o_push = 1'b1;
                    if (w_size_bad) begin
                        o_cmd.kind = lppd_pkg::CMD_ERR;
                        n_seen     = '0;
                        n_len      = '0;
                        n_discard  = !i_in_data.chunk_end;
                    end else begin
                        o_cmd.kind      = lppd_pkg::CMD_HDR;
                        o_cmd.last      = w_size_min;
                        n_busy[r_wbank] = 1'b1;
                        n_wbank         = ~r_wbank;
                        if (w_size_min) begin
                            n_seen = '0;
                            n_len  = '0;
                        end else begin
                            n_len = w_size[LEN_W-1:0];
                        end
                    end
                end
            end else begin
                o_push = 1'b1;
                if (w_seen_inc >= r_len) begin
                    o_cmd.last = 1'b1;
                    n_seen     = '0;
                    n_len      = '0;
                end else begin
                    n_seen = w_seen_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_len     <= '0;
            r_discard <= 1'b0;
            r_wbank   <= 1'b0;
            r_busy    <= '0;
        end else begin
            r_seen    <= n_seen;
            r_len     <= n_len;
            r_discard <= n_discard;
            r_wbank   <= n_wbank;
            r_busy    <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !r_discard && w_hdr_phase) begin
            r_hdr[r_wbank][w_hidx] <= i_in_data.rx_byte;
        end
    end

    assign o_hdr_bank = r_hdr;

endmodule

`default_nettype wire

// ===== src/lppd_back.sv =====
// Deframer back: pops commands, bursts headers out of the banks with the connection id
// patched in, and drives the output register. Depends on lppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppd_back #(
    parameter int HEADER_BYTES = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    input  wire lppd_pkg::t_cmd         i_cmd,
    input  wire logic [1:0][HEADER_BYTES-1:0][7:0] i_hdr_bank,
    input  wire logic [lppd_pkg::CONN_ID_W-1:0] i_conn_id,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output lppd_pkg::t_out              o_out_data,
    output lppd_pkg::t_hdr_done         o_hdr_done
);

    localparam int HIDX_W = $clog2(HEADER_BYTES);
    localparam logic [HIDX_W-1:0] LAST_IDX = HIDX_W'(HEADER_BYTES - 1);

    function automatic logic [7:0] patch_byte(
        input logic [7:0]                    hdr_byte,
        input logic [HIDX_W-1:0]             idx,
        input logic [lppd_pkg::CONN_ID_W-1:0] conn_id
    );
        logic [7:0] v;
        v = hdr_byte;
        for (int k = 0; k < lppd_pkg::ID_BYTES; k++) begin
            if (int'(idx) == lppd_pkg::ID_POS + k) begin
                v = conn_id[8*k +: 8];
            end
        end
        return v;
    endfunction

    lppd_pkg::t_back_state r_state, n_state;
    logic [HIDX_W-1:0]     r_idx, n_idx;
    logic                  r_bank, n_bank;
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    lppd_pkg::t_out        r_out_data, n_out_data;

    logic              w_load;
    logic              w_sel_bank;
    logic [HIDX_W-1:0] w_sel_idx;
    logic [7:0]        w_hdr_byte;

    assign w_load     = !r_out_valid || !i_out_stall;
    assign w_sel_bank = (r_state == lppd_pkg::BK_BURST) ? r_bank : i_cmd.bank;
    assign w_sel_idx  = (r_state == lppd_pkg::BK_BURST) ? r_idx : '0;
    assign w_hdr_byte = patch_byte(i_hdr_bank[w_sel_bank][w_sel_idx], w_sel_idx, i_conn_id);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lppd_pkg::BK_IDLE: begin
                if (w_load && !i_empty && i_cmd.kind == lppd_pkg::CMD_HDR) begin
                    n_state = lppd_pkg::BK_BURST;
                end
            end
            lppd_pkg::BK_BURST: begin
                if (w_load && r_idx == LAST_IDX) begin
                    n_state = lppd_pkg::BK_IDLE;
                end
            end
            default: n_state = lppd_pkg::BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_pop            = 1'b0;
        o_hdr_done.valid = 1'b0;
        o_hdr_done.bank  = r_bank;
        n_idx            = r_idx;
        n_bank           = r_bank;
        n_last           = r_last;
        n_out_valid      = r_out_valid;
        n_out_data       = r_out_data;
        case (r_state)
            lppd_pkg::BK_IDLE: begin
                if (w_load) begin
                    n_out_valid = 1'b0;
                    if (!i_empty) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data.size_error  = 1'b0;
                        n_out_data.packet_last = i_cmd.last;
                        n_out_data.out_byte    = i_cmd.data;
                        case (i_cmd.kind)
                            lppd_pkg::CMD_ERR: begin
                                n_out_data.out_byte    = '0;
                                n_out_data.packet_last = 1'b0;
                                n_out_data.size_error  = 1'b1;
                            end
                            lppd_pkg::CMD_HDR: begin
                                // first header byte goes out now, the rest follow
                                n_out_data.out_byte    = w_hdr_byte;
                                n_out_data.packet_last = 1'b0;
                                n_idx  = HIDX_W'(1);
                                n_bank = i_cmd.bank;
                                n_last = i_cmd.last;
                            end
                            default: begin
                                n_out_data.out_byte = i_cmd.data;
                            end
                        endcase
                    end
                end
            end
            lppd_pkg::BK_BURST: begin
                if (w_load) begin
                    n_out_valid            = 1'b1;
                    n_out_data.out_byte    = w_hdr_byte;
                    n_out_data.size_error  = 1'b0;
                    n_out_data.packet_last = r_last && (r_idx == LAST_IDX);
                    n_idx                  = r_idx + HIDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        // release the bank to the front
                        o_hdr_done.valid = 1'b1;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lppd_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_bank     <= n_bank;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== src/length_prefixed_packet_deframer_top.sv =====
// A body byte, a size error or a header's first byte passes the command queue and the output
// register; the rest of the header follows one byte a cycle while the output is not stalled.
// Throughput: one input and one output beat per cycle unless stalled, set by the single output
// register and the two header banks; a 32-entry command queue absorbs each header burst.
// Reset (synchronous, active low) clears the counters, discard flag, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_deframer_top #(
    parameter int HEADER_BYTES = 10,
    parameter int MAX_PACKET   = 6144
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire lppd_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output lppd_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [lppd_pkg::CONN_ID_W-1:0] i_cfg_data
);

    logic [lppd_pkg::CONN_ID_W-1:0] r_conn_id;

    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_empty;
    lppd_pkg::t_cmd       w_push_cmd;
    lppd_pkg::t_cmd       w_head_cmd;
    lppd_pkg::t_hdr_done  w_hdr_done;
    logic [$clog2(lppd_pkg::CMD_DEPTH):0]      w_count;
    logic [1:0][HEADER_BYTES-1:0][7:0]         w_hdr_bank;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn_id <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_conn_id <= i_cfg_data;
        end
    end

    lppd_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_PACKET   (MAX_PACKET)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_full     (w_full),
        .i_hdr_done (w_hdr_done),
        .o_hdr_bank (w_hdr_bank)
    );

    lppd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    lppd_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_cmd       (w_head_cmd),
        .i_hdr_bank  (w_hdr_bank),
        .i_conn_id   (r_conn_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_hdr_done  (w_hdr_done)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(lppd_pkg::CMD_DEPTH) + 1)'(lppd_pkg::CMD_DEPTH))
        else $error("command queue count out of range");

    a_error_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.size_error) |->
            (o_out_data.out_byte == 8'd0 && !o_out_data.packet_last))
        else $error("size error beat carries data or last flag");

    a_pop_only_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the length-prefixed packet deframer top level.
// Predicts every output beat from accepted input beats with its own model of the framing.
// Depends on lppd_pkg and length_prefixed_packet_deframer_top.
`timescale 1ns / 1ps

module tb_top;

    localparam int HDR_BYTES    = 10;
    localparam int MAX_PKT      = 6144;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_BEATS  = 45;
    localparam logic [7:0] FLUSH_BYTE = 8'hFF;

    class deframer_scoreboard;
        logic [31:0]     conn_id;
        logic [7:0]      hdr [HDR_BYTES];
        logic [12:0]     taken;
        logic [12:0]     pkt_len;
        bit              discarding;
        lppd_pkg::t_out  expected_q [$];
        int              errors;
        int              results;
        int              framed;

        function new();
            conn_id    = '0;
            taken      = '0;
            pkt_len    = '0;
            discarding = 1'b0;
            errors     = 0;
            results    = 0;
            framed     = 0;
        endfunction

        function void set_conn_id(logic [31:0] v);
            conn_id = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit mid_packet();
            return discarding || (taken != 0);
        endfunction

        // Work out the output beats caused by one accepted input beat.
        function void note_input(lppd_pkg::t_in d);
            logic [15:0]    size;
            lppd_pkg::t_out r;
            int             i;
            if (discarding) begin
                if (d.chunk_end) discarding = 1'b0;
                return;
            end
            framed++;
            if (taken < HDR_BYTES) begin
                hdr[taken] = d.rx_byte;
                taken++;
                if (taken < HDR_BYTES) return;
                size = {hdr[lppd_pkg::SIZE_HI_POS], hdr[lppd_pkg::SIZE_LO_POS]};
                if (size < HDR_BYTES || size > MAX_PKT) begin
                    r.out_byte    = 8'h00;
                    r.packet_last = 1'b0;
                    r.size_error  = 1'b1;
                    expected_q.push_back(r);
                    taken      = '0;
                    pkt_len    = '0;
                    discarding = !d.chunk_end;
                    return;
                end
                // Whole header is queued at once, id bytes swapped in low byte first
                for (i = 0; i < HDR_BYTES; i++) begin
                    if (i >= lppd_pkg::ID_POS && i < lppd_pkg::ID_POS + lppd_pkg::ID_BYTES)
                        r.out_byte = conn_id[8*(i-lppd_pkg::ID_POS) +: 8];
                    else
                        r.out_byte = hdr[i];
                    r.packet_last = (i == HDR_BYTES - 1) && (size == HDR_BYTES);
                    r.size_error  = 1'b0;
                    expected_q.push_back(r);
                end
                if (size == HDR_BYTES) begin
                    taken   = '0;
                    pkt_len = '0;
                end else begin
                    pkt_len = size[12:0];
                end
                return;
            end
            taken++;
            r.out_byte   = d.rx_byte;
            r.size_error = 1'b0;
            if (taken >= pkt_len) begin
                r.packet_last = 1'b1;
                taken   = '0;
                pkt_len = '0;
            end else begin
                r.packet_last = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(lppd_pkg::t_out got);
            lppd_pkg::t_out want;
            if (expected_q.size() == 0) begin
                $error("output beat %0h with nothing expected", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.packet_last !== want.packet_last) begin
                $error("packet_last: expected %0b, got %0b", want.packet_last, got.packet_last);
                errors++;
            end
            if (got.size_error !== want.size_error) begin
                $error("size_error: expected %0b, got %0b", want.size_error, got.size_error);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    lppd_pkg::t_in  in_beat;
    logic           out_valid;
    logic           out_stall;
    lppd_pkg::t_out out_beat;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [31:0]    cfg_data;

    deframer_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req_id;
    int cycles;

    length_prefixed_packet_deframer_top #(
        .HEADER_BYTES (HDR_BYTES),
        .MAX_PACKET   (MAX_PKT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall, plus a long hold-off whenever a new one is requested
    initial begin : receiver
        int hold_left;
        int hold_ack_id;
        hold_left   = 0;
        hold_ack_id = 0;
        out_stall   = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_ack_id != hold_req_id) begin
                hold_ack_id = hold_req_id;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_input(in_beat);
        if (rst_n && out_valid && !out_stall) sb.check_result(out_beat);
        if (rst_n && cfg_valid && cfg_ready) sb.set_conn_id(cfg_data);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one beat and hold it until taken; returns on the following falling edge.
    task automatic push_beat(input logic [7:0] b, input logic ce);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_beat.rx_byte   <= b;
        in_beat.chunk_end <= ce;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted beat has come out.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_conn_id(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One framed packet; fill < 0 means random bytes. A bad size sends the header only,
    // then some dropped bytes up to a chunk end unless the header closed the chunk.
    task automatic send_frame(input logic [15:0] size, input bit end_chunk, input int fill);
        int          total;
        int          i;
        int          junk;
        logic [7:0]  b;
        logic        ce;
        bit          bad;
        bad   = (size < HDR_BYTES) || (size > MAX_PKT);
        total = bad ? HDR_BYTES : int'(size);
        for (i = 0; i < total; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == lppd_pkg::SIZE_LO_POS) b = size[7:0];
            if (i == lppd_pkg::SIZE_HI_POS) b = size[15:8];
            ce = (i == total - 1) ? end_chunk : ($urandom_range(0, 99) < 8);
            push_beat(b, ce);
        end
        if (bad && !end_chunk) begin
            junk = $urandom_range(0, 4);
            repeat (junk) push_beat(8'($urandom), 1'b0);
            push_beat(8'($urandom), 1'b1);
        end
    endtask

    task automatic send_random_unit();
        int          pick;
        int          n;
        logic [15:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            n = $urandom_range(0, 99);
            if (n < 4)       size = 16'(HDR_BYTES);
            else if (n < 8)  size = 16'(HDR_BYTES + 1);
            else if (n < 94) size = 16'($urandom_range(12, 40));
            else             size = 16'($urandom_range(41, 120));
            send_frame(size, 1'($urandom_range(0, 1)), -1);
        end else if (pick < 90) begin
            case ($urandom_range(0, 4))
                0:       size = 16'h0000;
                1:       size = 16'(HDR_BYTES - 1);
                2:       size = 16'(MAX_PKT + 1);
                3:       size = 16'($urandom_range(0, HDR_BYTES - 1));
                default: size = 16'($urandom_range(MAX_PKT + 2, 65535));
            endcase
            send_frame(size, 1'($urandom_range(0, 1)), -1);
        end else begin
            // Stray bytes, then flush bytes until no packet is open; a header gets a hopeless size
            n = $urandom_range(1, 3);
            repeat (n) push_beat(8'($urandom), 1'($urandom_range(0, 1)));
            while (sb.mid_packet()) push_beat(FLUSH_BYTE, 1'b1);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int beats,
                             input logic [31:0] id);
        int target;
        settle();
        write_conn_id(id);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = sb.framed + beats;
        while (sb.framed < target) send_random_unit();
    endtask

    initial begin
        sb             = new();
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_id    = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: header-only packet of zeros under the reset id, then a bad size
        // whose header leaves the chunk open so the following bytes get dropped.
        send_frame(16'(HDR_BYTES), 1'b1, 8'h00);
        send_frame(16'hFFFF, 1'b0, 8'hFF);

        // No idling, under an all-ones id
        run_phase(0, 0, PHASE_BEATS, 32'hFFFF_FFFF);
        run_phase(68, 0, PHASE_BEATS, 32'h0000_0000);
        run_phase(0, 68, PHASE_BEATS, $urandom);
        run_phase(16, 16, PHASE_BEATS, $urandom);

        // Back-pressure: hold the output while the sender keeps pushing a long packet
        settle();
        write_conn_id(32'h8000_0001);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_id    = hold_req_id + 1;
        send_frame(16'd60, 1'b1, -1);
        settle();
        run_phase(16, 16, 20, $urandom);

        settle();
        $display("Checked %0d output beats from %0d framed input beats under mixed pacing,",
                 sb.results, sb.framed);
        $display("with header-only, bad-size, dropped and held-off traffic.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== length_prefixed_packet_deframer_top.f =====
src/lppd_pkg.sv
src/lppd_cmd_fifo.sv
src/lppd_front.sv
src/lppd_back.sv
src/length_prefixed_packet_deframer_top.sv
sim/tb_top.sv
